// ----- rtl/sliding_window_maximum_top_defines.svh -----
// Assertion macros for the sliding window maximum block.
// Included by the modules that check their own control logic.
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// Next-cycle implication, disabled during reset.
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

// ----- rtl/swm_pkg.sv -----
// Shared types and constants for the sliding window maximum block.
// No dependencies; used by every other file of the block but the assertion header.
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int LEN_W          = 5;
  localparam int WINDOW_MAX_DEF = 16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } swm_state_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic [LEN_W-1:0] len;
  } swm_ctl_t;

endpackage

// ----- rtl/swm_in_if.sv -----
// Input sample channel: valid/ready handshake with sample and end-of-array mark.
// Depends on swm_pkg for the sample width.
interface swm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::SAMPLE_W-1:0]  sample;
  logic                                 last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ----- rtl/swm_out_if.sv -----
// Result channel: valid/ready handshake with window maximum and end-of-array mark.
// Depends on swm_pkg for the sample width.
interface swm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::SAMPLE_W-1:0]  window_max;
  logic                                 last_result;

  modport source (output valid, window_max, last_result, input ready);
  modport sink   (input valid, window_max, last_result, output ready);
endinterface

// ----- rtl/swm_cell.sv -----
// One window cell: holds one stored sample and folds it into the passing maximum.
// Depends on swm_pkg.
module swm_cell (
  input  logic                                clk,
  input  logic                                shift,
  input  logic                                include_en,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] cand_in,
  output logic signed [swm_pkg::SAMPLE_W-1:0] sample_out,
  output logic signed [swm_pkg::SAMPLE_W-1:0] cand_out
);

  logic signed [swm_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] cand_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] cand_nxt;

  always_comb begin
    cand_nxt = cand_in;
    if (include_en && (sample_r > cand_in)) begin
      cand_nxt = sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_r <= sample_in;
    end
    cand_r <= cand_nxt;
  end

  assign sample_out = sample_r;
  assign cand_out   = cand_r;

endmodule

// ----- rtl/swm_ctrl.sv -----
// Control for the sliding window maximum: window length register, fill count,
// scan sequencer and handshakes. Depends on swm_pkg and the assertion header.
`include "sliding_window_maximum_top_defines.svh"

module swm_ctrl #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [swm_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_last,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_last,
  output swm_pkg::swm_ctl_t          ctl
);

  localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_CAP = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;

  swm_pkg::swm_state_t         state_r, state_nxt;
  logic [swm_pkg::LEN_W-1:0]   win_len_r;
  logic [swm_pkg::LEN_W-1:0]   eff_len;
  logic [FILL_W-1:0]           fill_r, fill_nxt, fill_inc;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        last_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_last_r;
  logic                        out_free;
  logic                        load;
  logic                        accept;
  logic                        emit;
  logic                        scan_done;

  always_comb begin
    eff_len = win_len_r;
    if (win_len_r == '0) begin
      eff_len = swm_pkg::LEN_W'(1);
    end else if (32'(win_len_r) > LEN_CAP) begin
      eff_len = swm_pkg::LEN_W'(LEN_CAP);
    end
  end

  assign fill_inc  = (32'(fill_r) == WINDOW_MAX) ? fill_r : fill_r + FILL_W'(1);
  assign emit      = 32'(fill_inc) >= 32'(eff_len);
  assign scan_done = cnt_r == CNT_W'(WINDOW_MAX - 1);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        if (in_valid && emit) begin
          state_nxt = swm_pkg::ST_SCAN;
        end
      end
      swm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = swm_pkg::ST_OUT;
        end
      end
      swm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    case (state_r)
      swm_pkg::ST_IDLE: in_ready = 1'b1;
      swm_pkg::ST_SCAN: in_ready = 1'b0;
      swm_pkg::ST_OUT:  load     = out_free;
      default:          in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = in_last ? '0 : fill_inc;
    end
    cnt_nxt = '0;
    if (state_r == swm_pkg::ST_SCAN) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      win_len_r   <= swm_pkg::LEN_W'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last;
    end
    if (load) begin
      out_last_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign ctl.shift = accept;
  assign ctl.load  = load;
  assign ctl.len   = eff_len;

  `SWM_ASSERT_NXT(a_no_result_stays_idle, clk, rst_n, accept && !emit, state_r == swm_pkg::ST_IDLE)
  `SWM_ASSERT_NXT(a_scan_holds, clk, rst_n, state_r == swm_pkg::ST_SCAN && !scan_done, state_r == swm_pkg::ST_SCAN)
  `SWM_ASSERT_NXT(a_last_clears_fill, clk, rst_n, accept && in_last, fill_r == '0)
  `SWM_ASSERT_IMP(a_result_after_scan, clk, rst_n, $rose(out_valid), $past(state_r) == swm_pkg::ST_OUT)

endmodule

// ----- rtl/sliding_window_maximum_top.sv -----
// Sliding window maximum: one signed sample per transfer in, the maximum of the
// last window_len samples out. Use: drive in_ch (sample, last_sample) and take
// results from out_ch (window_max, last_result), both valid/ready; a transfer
// happens when valid and ready are high at a rising clk edge. cfg_we/cfg_wdata
// write window_len (0 acts as 1, values above WINDOW_MAX saturate); write only
// while idle. A sample that does not complete a window gives no result. A
// sample that does raises out_ch valid after its transfer: the running maximum
// walks the chain of WINDOW_MAX cells, one cell per cycle, and then loads the
// output register. The next sample is taken only after that load. The output
// register holds a result while the receiver stalls; a newer result waits in
// the chain until the held one transfers, and the input stalls meanwhile. A
// sample with last_sample set marks its result and empties the window; an
// array shorter than the window gives no result. Synchronous active-low reset
// sets window_len to 1, empties the window and drops any pending result.
// Depends on swm_pkg, swm_in_if, swm_out_if, swm_cell and swm_ctrl.
module sliding_window_maximum_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [swm_pkg::LEN_W-1:0] cfg_wdata,
  swm_in_if.sink                    in_ch,
  swm_out_if.source                 out_ch
);

  swm_pkg::swm_ctl_t                   ctl;
  logic signed [swm_pkg::SAMPLE_W-1:0] samp [WINDOW_MAX];
  logic signed [swm_pkg::SAMPLE_W-1:0] cand [WINDOW_MAX];
  logic signed [swm_pkg::SAMPLE_W-1:0] max_r;

  swm_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_sample),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last_result),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [swm_pkg::SAMPLE_W-1:0] sample_in;
    logic signed [swm_pkg::SAMPLE_W-1:0] cand_in;

    if (i == 0) begin : g_head
      assign sample_in = in_ch.sample;
      assign cand_in   = swm_pkg::SAMPLE_MIN;
    end else begin : g_body
      assign sample_in = samp[i-1];
      assign cand_in   = cand[i-1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .shift      (ctl.shift),
      .include_en (32'(i) < 32'(ctl.len)),
      .sample_in  (sample_in),
      .cand_in    (cand_in),
      .sample_out (samp[i]),
      .cand_out   (cand[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      max_r <= cand[WINDOW_MAX-1];
    end
  end

  assign out_ch.window_max = max_r;

endmodule
